// ----- hdl/sdfb_pkg.sv -----
// ----------------------------------------------------------------------------
// Slow data frame builder package
// Shared constants, beat layouts and register map for the frame builder.
// ----------------------------------------------------------------------------
package sdfb_pkg;

  localparam int unsigned MsgRegs    = 5;
  localparam int unsigned RegW       = 32;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned MsgBlocks  = 4;
  localparam int unsigned BlockChars = 5;
  localparam int unsigned PosBytes   = 5;

  localparam logic [RegW-1:0] MsgRegReset = 32'h2020_2020;

  localparam logic [7:0] SfPerMsg     = 8'd60;
  localparam logic [4:0] LastFrame    = 5'd20;
  localparam logic [4:0] MsgLastFrame = 5'd8;
  localparam logic [7:0] HdrText      = 8'h40;
  localparam logic [7:0] HdrPos       = 8'h30;
  localparam logic [7:0] Filler       = 8'h66;
  localparam logic [2:0] MinTailCount = 3'd2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MSG_0_3   = 3'd0,
    REG_MSG_4_7   = 3'd1,
    REG_MSG_8_11  = 3'd2,
    REG_MSG_12_15 = 3'd3,
    REG_MSG_16_19 = 3'd4
  } cfg_reg_e;

  // message characters, block b character j
  typedef logic [MsgBlocks-1:0][BlockChars-1:0][7:0] msg_t;

  // lowest bit first: new_transmission, frame_number, position_count,
  // position_byte_0 .. position_byte_4
  typedef struct packed {
    logic [PosBytes-1:0][7:0] position_byte;
    logic [2:0]               position_count;
    logic [4:0]               frame_number;
    logic                     new_transmission;
  } in_item_t;

  // lowest bit first: data_present, slow_byte_0, slow_byte_1, slow_byte_2
  typedef struct packed {
    logic [7:0] slow_byte_2;
    logic [7:0] slow_byte_1;
    logic [7:0] slow_byte_0;
    logic       data_present;
  } out_item_t;

  localparam int unsigned InW       = $bits(in_item_t);
  localparam int unsigned OutW      = $bits(out_item_t);
  localparam int unsigned InTdataW  = ((InW + 7) / 8) * 8;
  localparam int unsigned OutTdataW = ((OutW + 7) / 8) * 8;

endpackage

// ----- hdl/sdfb_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Slow data frame builder message registers
// Holds the 20-character text message written through the config port.
// ----------------------------------------------------------------------------
module sdfb_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sdfb_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [sdfb_pkg::RegW-1:0]      cfg_wdata_i,
  output sdfb_pkg::msg_t                 msg_o
);
  import sdfb_pkg::*;

  logic [MsgRegs-1:0][RegW-1:0] msg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msg_q <= {MsgRegs{MsgRegReset}};
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_MSG_0_3:   msg_q[0] <= cfg_wdata_i;
        REG_MSG_4_7:   msg_q[1] <= cfg_wdata_i;
        REG_MSG_8_11:  msg_q[2] <= cfg_wdata_i;
        REG_MSG_12_15: msg_q[3] <= cfg_wdata_i;
        REG_MSG_16_19: msg_q[4] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign msg_o = msg_q;

endmodule

// ----- hdl/sdfb_core.sv -----
// ----------------------------------------------------------------------------
// Slow data frame builder core
// Superframe counter, latched position data and slow-data field selection.
// ----------------------------------------------------------------------------
module sdfb_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  sdfb_pkg::in_item_t   item_i,
  input  sdfb_pkg::msg_t       msg_i,
  output sdfb_pkg::out_item_t  res_o
);
  import sdfb_pkg::*;

  logic [5:0]               sf_q, sf_d, sf_eff, sf_inc;
  logic [2:0]               lc_q, lc_d;
  logic [PosBytes-1:0][7:0] lb_q, lb_d;

  logic                         present, odd, msg_path;
  logic [4:0]                   fm1;
  logic [1:0]                   blk;
  logic [BlockChars-1:0][7:0]   blk_chars;

  always_comb begin
    sf_eff    = item_i.new_transmission ? 6'd0 : sf_q;
    present   = item_i.frame_number != 5'd0;
    odd       = item_i.frame_number[0];
    msg_path  = (sf_eff == 6'd0) && (item_i.frame_number <= MsgLastFrame);
    fm1       = item_i.frame_number - 5'd1;
    blk       = fm1[2:1];
    blk_chars = msg_i[blk];

    lc_d  = lc_q;
    lb_d  = lb_q;
    res_o = '0;
    res_o.data_present = present;

    if (present) begin
      if (msg_path) begin
        if (odd) begin
          res_o.slow_byte_0 = HdrText + {6'd0, blk};
          res_o.slow_byte_1 = blk_chars[0];
          res_o.slow_byte_2 = blk_chars[1];
        end else begin
          res_o.slow_byte_0 = blk_chars[2];
          res_o.slow_byte_1 = blk_chars[3];
          res_o.slow_byte_2 = blk_chars[4];
        end
      end else if (odd) begin
        lc_d = item_i.position_count;
        lb_d = item_i.position_byte;
        if (item_i.position_count == 3'd0) begin
          res_o.slow_byte_0 = Filler;
          res_o.slow_byte_1 = Filler;
          res_o.slow_byte_2 = Filler;
        end else begin
          res_o.slow_byte_0 = HdrPos + {5'd0, item_i.position_count};
          res_o.slow_byte_1 = item_i.position_byte[0];
          res_o.slow_byte_2 = item_i.position_byte[1];
        end
      end else if (lc_q <= MinTailCount) begin
        res_o.slow_byte_0 = Filler;
        res_o.slow_byte_1 = Filler;
        res_o.slow_byte_2 = Filler;
      end else begin
        res_o.slow_byte_0 = lb_q[2];
        res_o.slow_byte_1 = lb_q[3];
        res_o.slow_byte_2 = lb_q[4];
      end
    end

    sf_inc = sf_eff + 6'd1;
    sf_d   = sf_eff;
    if (item_i.frame_number >= LastFrame) begin
      sf_d = ({2'd0, sf_inc} >= SfPerMsg) ? 6'd0 : sf_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sf_q <= '0;
      lc_q <= '0;
      lb_q <= '0;
    end else if (en_i) begin
      sf_q <= sf_d;
      lc_q <= lc_d;
      lb_q <= lb_d;
    end
  end

endmodule

// ----- hdl/slow_data_frame_builder_top.sv -----
// Path: an input beat passes the input register, then the result register, to the master side.
// Throughput: one beat per cycle; input register and result register stall
// only when the result register is full and m_axis_tready_i is low.
// Reset: pipeline empties, superframe counter and latched position data clear,
// message registers return to four spaces each.
// ----------------------------------------------------------------------------
// Slow data frame builder top
// Builds the 3-byte slow-data field of each voice frame from stream beats.
// ----------------------------------------------------------------------------
module slow_data_frame_builder_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // new_transmission, frame_number, position_count, position_byte_0..4
  input  logic [sdfb_pkg::InTdataW-1:0]      s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // data_present, slow_byte_0, slow_byte_1, slow_byte_2
  output logic [sdfb_pkg::OutTdataW-1:0]     m_axis_tdata_o,
  input  logic                               cfg_we_i,
  input  logic [sdfb_pkg::CfgIdxW-1:0]       cfg_index_i,
  input  logic [sdfb_pkg::RegW-1:0]          cfg_wdata_i
);
  import sdfb_pkg::*;

  logic      in_valid_q, out_valid_q, advance;
  in_item_t  in_q;
  out_item_t out_q, res;
  msg_t      msg;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  sdfb_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .msg_o       (msg)
  );

  sdfb_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .item_i (in_q),
    .msg_i  (msg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_q <= in_item_t'(s_axis_tdata_i[InW-1:0]);
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OutTdataW - OutW){1'b0}}, out_q};

  a_stall_only_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (in_valid_q && out_valid_q && !m_axis_tready_i))
    else $error("input stalled while the pipeline can move");

  a_hold_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> in_valid_q)
    else $error("pending input beat dropped");

  a_result_from_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_valid_q))
    else $error("result beat without an input beat");

  a_frame_zero_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.data_present) |->
      (out_q.slow_byte_0 == 8'd0 && out_q.slow_byte_1 == 8'd0 &&
       out_q.slow_byte_2 == 8'd0))
    else $error("frame zero carries slow data");

endmodule

// ----- sim/slow_data_frame_builder_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slow data frame builder testbench
// Streams voice-frame beats into the builder and checks every slow-data
// field against an in-bench prediction of the message, position and filler
// paths. Exercises several message settings, superframe wrap, random
// idling on both sides and a long receiver hold-off.
// ----------------------------------------------------------------------------
module slow_data_frame_builder_top_tb;
  import sdfb_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned HoldCycles = 48;

  class slow_field_board;
    logic [RegW-1:0] msg_reg [MsgRegs];
    logic [5:0]      superframe;
    logic [2:0]      held_count;
    logic [7:0]      held_byte [PosBytes];
    out_item_t       pending_fields[$];
    int              errors;
    int              frames_seen;
    int              fields_checked;
    int              text_fields;
    int              wraps;

    function new();
      for (int r = 0; r < MsgRegs; r++) msg_reg[r] = MsgRegReset;
      for (int k = 0; k < PosBytes; k++) held_byte[k] = '0;
      superframe     = '0;
      held_count     = '0;
      errors         = 0;
      frames_seen    = 0;
      fields_checked = 0;
      text_fields    = 0;
      wraps          = 0;
    endfunction

    function void set_reg(int unsigned r, logic [RegW-1:0] v);
      msg_reg[r] = v;
    endfunction

    function logic [7:0] text_char(int unsigned n);
      return msg_reg[n >> 2][(n % 4) * 8 +: 8];
    endfunction

    function void note_frame(in_item_t it);
      out_item_t   f;
      int unsigned blk;
      int unsigned base;
      logic [5:0]  nxt;
      f = '0;
      frames_seen++;
      if (it.new_transmission) superframe = '0;
      if (it.frame_number != '0) begin
        f.data_present = 1'b1;
        if (superframe == '0 && it.frame_number <= MsgLastFrame) begin
          blk  = (int'(it.frame_number) - 1) >> 1;
          base = blk * BlockChars;
          text_fields++;
          if (it.frame_number[0]) begin
            f.slow_byte_0 = HdrText + 8'(blk);
            f.slow_byte_1 = text_char(base);
            f.slow_byte_2 = text_char(base + 1);
          end else begin
            f.slow_byte_0 = text_char(base + 2);
            f.slow_byte_1 = text_char(base + 3);
            f.slow_byte_2 = text_char(base + 4);
          end
        end else if (it.frame_number[0]) begin
          held_count = it.position_count;
          for (int k = 0; k < PosBytes; k++) held_byte[k] = it.position_byte[k];
          if (held_count == '0) begin
            f.slow_byte_0 = Filler;
            f.slow_byte_1 = Filler;
            f.slow_byte_2 = Filler;
          end else begin
            f.slow_byte_0 = HdrPos + {5'b0, held_count};
            f.slow_byte_1 = held_byte[0];
            f.slow_byte_2 = held_byte[1];
          end
        end else if (held_count <= MinTailCount) begin
          f.slow_byte_0 = Filler;
          f.slow_byte_1 = Filler;
          f.slow_byte_2 = Filler;
        end else begin
          f.slow_byte_0 = held_byte[2];
          f.slow_byte_1 = held_byte[3];
          f.slow_byte_2 = held_byte[4];
        end
      end
      if (it.frame_number >= LastFrame) begin
        nxt = superframe + 6'd1;
        if ({2'b0, nxt} >= SfPerMsg) begin
          nxt = '0;
          wraps++;
        end
        superframe = nxt;
      end
      pending_fields.push_back(f);
    endfunction

    function void check_field(out_item_t got);
      out_item_t want;
      if (pending_fields.size() == 0) begin
        $error("unexpected field beat %h", got);
        errors++;
        return;
      end
      want = pending_fields.pop_front();
      fields_checked++;
      if (got.data_present !== want.data_present) begin
        $error("data_present expected %0h actual %0h", want.data_present, got.data_present);
        errors++;
      end
      if (got.slow_byte_0 !== want.slow_byte_0) begin
        $error("slow_byte_0 expected %0h actual %0h", want.slow_byte_0, got.slow_byte_0);
        errors++;
      end
      if (got.slow_byte_1 !== want.slow_byte_1) begin
        $error("slow_byte_1 expected %0h actual %0h", want.slow_byte_1, got.slow_byte_1);
        errors++;
      end
      if (got.slow_byte_2 !== want.slow_byte_2) begin
        $error("slow_byte_2 expected %0h actual %0h", want.slow_byte_2, got.slow_byte_2);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [InTdataW-1:0]  s_tdata;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [OutTdataW-1:0] m_tdata;
  logic                 cfg_we;
  logic [CfgIdxW-1:0]   cfg_index;
  logic [RegW-1:0]      cfg_wdata;

  slow_field_board board;
  bit              quiet;
  bit              hold_go;
  bit              hold_done;
  int              hold_left;
  int              stall_cycles;

  slow_data_frame_builder_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_wdata_i     (cfg_wdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // receiver side: random back-pressure plus one long hold-off
  always @(posedge clk_i) begin
    if (hold_go && !hold_done) begin
      hold_left = HoldCycles;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (quiet) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= 18);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_tvalid && m_tready) board.check_field(m_tdata[OutW-1:0]);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= StallLimit) begin
        $display("slow_data_frame_builder_top verification failed");
        $finish;
      end
    end
  end

  function automatic in_item_t make_frame(bit nt, logic [4:0] fn, logic [2:0] cnt,
                                          logic [39:0] bytes);
    in_item_t it;
    it.new_transmission = nt;
    it.frame_number     = fn;
    it.position_count   = cnt;
    it.position_byte    = bytes;
    return it;
  endfunction

  task automatic send_frame(in_item_t it);
    while (!quiet && $urandom_range(99) < 18) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= InTdataW'(it);
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    board.note_frame(it);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.pending_fields.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // mode 0: all zero, 1: all ones, otherwise random values
  task automatic program_message(int mode);
    logic [RegW-1:0] v;
    for (int r = 0; r < MsgRegs; r++) begin
      v = (mode == 0) ? '0 : (mode == 1) ? '1 : RegW'($urandom());
      cfg_we    <= 1'b1;
      cfg_index <= cfg_reg_e'(r);
      cfg_wdata <= v;
      @(posedge clk_i);
      board.set_reg(r, v);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [39:0] rand_bytes();
    return {8'($urandom()), 32'($urandom())};
  endfunction

  function automatic logic [2:0] rand_count();
    return ($urandom_range(9) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
  endfunction

  task automatic directed_frames();
    send_frame(make_frame(1'b1, 5'd1, 3'd5, '1));
    for (int f = 2; f <= 8; f++) send_frame(make_frame(1'b0, 5'(f), 3'd0, rand_bytes()));
    send_frame(make_frame(1'b0, 5'd0, 3'd5, '1));
    send_frame(make_frame(1'b0, 5'd9, 3'd5, 40'hff_ee_dd_cc_bb));
    send_frame(make_frame(1'b0, 5'd10, 3'd0, '0));
    send_frame(make_frame(1'b0, 5'd20, 3'd0, '0));
    send_frame(make_frame(1'b0, 5'd1, 3'd0, '1));
    send_frame(make_frame(1'b0, 5'd2, 3'd0, '0));
    send_frame(make_frame(1'b0, 5'd3, 3'd2, 40'h01_02_03_04_05));
    send_frame(make_frame(1'b0, 5'd4, 3'd5, '1));
    send_frame(make_frame(1'b0, 5'd5, 3'd7, '0));
    send_frame(make_frame(1'b0, 5'd6, 3'd0, '1));
    send_frame(make_frame(1'b0, 5'd7, 3'd3, '1));
    send_frame(make_frame(1'b0, 5'd8, 3'd0, '0));
    send_frame(make_frame(1'b0, 5'd31, 3'd6, rand_bytes()));
    send_frame(make_frame(1'b0, 5'd22, 3'd1, rand_bytes()));
    send_frame(make_frame(1'b1, 5'd0, 3'd4, rand_bytes()));
    send_frame(make_frame(1'b0, 5'd1, 3'd0, '0));
    send_frame(make_frame(1'b0, 5'd12, 3'd0, '0));
  endtask

  task automatic random_frames(int n);
    int       sent;
    int       kind;
    int       len;
    bit       nt;
    in_item_t it;
    logic [63:0] r;
    sent = 0;
    while (sent < n) begin
      kind = $urandom_range(9);
      if (kind <= 6) begin
        nt = ($urandom_range(2) == 0);
        for (int f = 0; f <= LastFrame; f++) begin
          if ($urandom_range(19) == 0) continue;
          send_frame(make_frame(nt && f == 0, 5'(f), rand_count(), rand_bytes()));
          sent++;
        end
      end else if (kind == 7) begin
        len = $urandom_range(3, 20);
        for (int i = 0; i < len; i++) begin
          it = make_frame($urandom_range(15) == 0,
                          ($urandom_range(3) == 0) ? 5'($urandom_range(21, 31)) : LastFrame,
                          rand_count(), rand_bytes());
          send_frame(it);
          sent++;
        end
      end else begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          r  = {$urandom(), $urandom()};
          it = r[InW-1:0];
          send_frame(it);
          sent++;
        end
      end
    end
  endtask

  initial begin
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    m_tready     = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    quiet        = 1'b0;
    hold_go      = 1'b0;
    hold_done    = 1'b0;
    hold_left    = 0;
    stall_cycles = 0;
    board        = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    directed_frames();
    drain();
    program_message(0);
    random_frames(90);
    drain();

    // sweep the superframe counter through its wrap with no idling
    program_message(1);
    quiet = 1'b1;
    send_frame(make_frame(1'b1, LastFrame, 3'd0, '0));
    for (int i = 0; i < SfPerMsg; i++) send_frame(make_frame(1'b0, LastFrame, 3'd0, '0));
    for (int f = 1; f <= MsgLastFrame; f++) send_frame(make_frame(1'b0, 5'(f), 3'd0, '0));
    quiet = 1'b0;
    random_frames(50);
    drain();

    program_message(2);
    hold_go = 1'b1;
    random_frames(160);
    drain();

    program_message(2);
    random_frames(40);
    drain();
    repeat (8) @(posedge clk_i);

    if (board.pending_fields.size() != 0) begin
      $error("%0d expected fields never arrived", board.pending_fields.size());
      board.errors++;
    end
    $display("Run sent %0d voice frames and checked %0d slow-data fields.",
             board.frames_seen, board.fields_checked);
    $display("Text-message fields: %0d, superframe counter wraps: %0d.",
             board.text_fields, board.wraps);
    if (board.errors == 0) begin
      $display("slow_data_frame_builder_top verification clean");
    end else begin
      $display("slow_data_frame_builder_top verification failed");
    end
    $finish;
  end

endmodule
